@@ hw/rtl/ptp_pkg.sv @@
package ptp_pkg;

  // Largest image side; wider settings saturate to this.
  localparam int unsigned MAX_SIDE = 4096;

  // Q0.16 constants; ONE_Q16 is 1.0 and needs a 17th bit.
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [15:0] K_SEVEN_TENTHS = 16'd45875;
  localparam logic [15:0] K_THREE_TENTHS = 16'd19660;
  localparam logic [15:0] K_TWO_TENTHS = 16'd13107;
  localparam logic [15:0] K_ONE_TENTH = 16'd6553;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_WIDTH = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_BASE = 3'd3;
  localparam logic [2:0] REG_TOP = 3'd4;
  localparam logic [2:0] REG_BOTTOM = 3'd5;

  // Modes.
  localparam logic [1:0] MODE_VIGNETTE = 2'd0;
  localparam logic [1:0] MODE_GRADIENT = 2'd1;
  localparam logic [1:0] MODE_SKY = 2'd2;

  // Pipeline shape.
  localparam int SQ_STAGES = 21;
  localparam int DV_STAGES = 17;

endpackage

@@ hw/rtl/procedural_texture_pixel_top.sv @@
// Procedural texture pixel generator: pixel coordinate in, RGB word out.
//
// Input channel: a coordinate word (pos_x, pos_y) is taken at each rising
// edge where start is high and busy is low. busy stays low, so a new word
// may enter every clock: one pixel per cycle sustained.
// Output channel: red, green and blue are shown for one cycle with done
// high. The receiver cannot stall, so no back pressure exists.
// The pipeline is set by the 21-step square root (one result bit a stage)
// and the 17-step restoring divider (one quotient bit a stage), with
// registers for the input word, the center offsets, the squared distance,
// the divider setup, the scale factors and the channel products.
// Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high,
// cfg_index selects mode, image_width, image_height, the shading color,
// the first-row color and the last-row color (0 to 5). Write it only while
// the pipeline is empty. Reset (rst, synchronous) empties the pipeline and
// restores the default register values.
module procedural_texture_pixel_top
  import ptp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [1:0]  mode;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic [23:0] shade_rgb;
  logic [23:0] ramp_first_rgb;
  logic [23:0] ramp_last_rgb;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_VIGNETTE;
      image_width <= 13'd512;
      image_height <= 13'd512;
      shade_rgb <= 24'h87CEEB;
      ramp_first_rgb <= 24'h87CEEB;
      ramp_last_rgb <= 24'h4682B4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: mode <= cfg_data[1:0];
        REG_WIDTH: image_width <= cfg_data[12:0];
        REG_HEIGHT: image_height <= cfg_data[12:0];
        REG_BASE: shade_rgb <= cfg_data;
        REG_TOP: ramp_first_rgb <= cfg_data;
        REG_BOTTOM: ramp_last_rgb <= cfg_data;
        default: ;
      endcase
    end
  end

  // Values derived from the configuration, refreshed every cycle.
  logic [12:0] w_sat;
  logic [12:0] h_sat;
  logic [27:0] vig_den;
  logic [11:0] row_den;
  logic        h_small;

  always_ff @(posedge clk) begin
    w_sat <= (image_width > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : image_width;
    h_sat <= (image_height > 13'(MAX_SIDE)) ? 13'(MAX_SIDE) : image_height;
    vig_den <= 28'(w_sat * K_SEVEN_TENTHS);
    row_den <= 12'(h_sat - 13'd1);
    h_small <= (h_sat < 13'd2);
  end

  // Stage 0: input word.
  logic        s0_v;
  logic [11:0] s0_x;
  logic [11:0] s0_y;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else s0_v <= start;
    s0_x <= pos_x;
    s0_y <= pos_y;
  end

  // Stage 1: offsets from the center.
  logic               s1_v;
  logic signed [13:0] s1_dx;
  logic signed [13:0] s1_dy;
  logic [11:0]        s1_y;

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else s1_v <= s0_v;
    s1_dx <= $signed({2'b00, s0_x}) - $signed({2'b00, w_sat[12:1]});
    s1_dy <= $signed({2'b00, s0_y}) - $signed({2'b00, h_sat[12:1]});
    s1_y <= s0_y;
  end

  // Stage 2: squared distance.
  logic        s2_v;
  logic [25:0] s2_d2;
  logic [11:0] s2_y;
  logic [27:0] sq_dx;
  logic [27:0] sq_dy;

  assign sq_dx = 28'(s1_dx * s1_dx);
  assign sq_dy = 28'(s1_dy * s1_dy);

  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else s2_v <= s1_v;
    s2_d2 <= 26'(sq_dx + sq_dy);
    s2_y <= s1_y;
  end

  // Square root of d2 * 65536, one root bit per stage.
  logic        sq_v    [0:SQ_STAGES];
  logic [41:0] sq_bits [0:SQ_STAGES];
  logic [23:0] sq_rem  [0:SQ_STAGES];
  logic [20:0] sq_root [0:SQ_STAGES];
  logic [11:0] sq_y    [0:SQ_STAGES];

  assign sq_v[0] = s2_v;
  assign sq_bits[0] = {s2_d2, 16'd0};
  assign sq_rem[0] = '0;
  assign sq_root[0] = '0;
  assign sq_y[0] = s2_y;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [23:0] rem_sh;
    logic [23:0] trial;
    assign rem_sh = {sq_rem[k][21:0], sq_bits[k][41:40]};
    assign trial = {1'b0, sq_root[k], 2'b01};
    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else sq_v[k+1] <= sq_v[k];
      sq_bits[k+1] <= {sq_bits[k][39:0], 2'b00};
      sq_y[k+1] <= sq_y[k];
      if (rem_sh >= trial) begin
        sq_rem[k+1] <= rem_sh - trial;
        sq_root[k+1] <= {sq_root[k][19:0], 1'b1};
      end else begin
        sq_rem[k+1] <= rem_sh;
        sq_root[k+1] <= {sq_root[k][19:0], 1'b0};
      end
    end
  end

  // Divider setup: numerators and the saturation checks.
  logic        dv_v     [0:DV_STAGES];
  logic [44:0] dv_frem  [0:DV_STAGES];
  logic [16:0] dv_fq    [0:DV_STAGES];
  logic        dv_fsat  [0:DV_STAGES];
  logic [28:0] dv_trem  [0:DV_STAGES];
  logic [16:0] dv_tq    [0:DV_STAGES];
  logic        dv_tsat  [0:DV_STAGES];

  logic [44:0] f_num;
  logic [28:0] t_num;

  assign f_num = {sq_root[SQ_STAGES], 24'd0};
  assign t_num = {1'b0, sq_y[SQ_STAGES], 16'd0};

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else dv_v[0] <= sq_v[SQ_STAGES];
    dv_frem[0] <= f_num;
    dv_fq[0] <= '0;
    dv_fsat[0] <= (f_num >= {vig_den, 17'd0});
    dv_trem[0] <= t_num;
    dv_tq[0] <= '0;
    dv_tsat[0] <= h_small || (t_num >= {row_den, 17'd0});
  end

  // Restoring division, one quotient bit per stage for both quotients.
  for (genvar j = 0; j < DV_STAGES; j++) begin : g_div
    logic [44:0] f_sub;
    logic [28:0] t_sub;
    assign f_sub = {17'd0, vig_den} << (DV_STAGES - 1 - j);
    assign t_sub = {17'd0, row_den} << (DV_STAGES - 1 - j);
    always_ff @(posedge clk) begin
      if (rst) dv_v[j+1] <= 1'b0;
      else dv_v[j+1] <= dv_v[j];
      dv_fsat[j+1] <= dv_fsat[j];
      dv_tsat[j+1] <= dv_tsat[j];
      if (dv_frem[j] >= f_sub) begin
        dv_frem[j+1] <= dv_frem[j] - f_sub;
        dv_fq[j+1] <= {dv_fq[j][15:0], 1'b1};
      end else begin
        dv_frem[j+1] <= dv_frem[j];
        dv_fq[j+1] <= {dv_fq[j][15:0], 1'b0};
      end
      if (dv_trem[j] >= t_sub) begin
        dv_trem[j+1] <= dv_trem[j] - t_sub;
        dv_tq[j+1] <= {dv_tq[j][15:0], 1'b1};
      end else begin
        dv_trem[j+1] <= dv_trem[j];
        dv_tq[j+1] <= {dv_tq[j][15:0], 1'b0};
      end
    end
  end

  // Clamp the factors to one; the row factor is zero when the height is below two.
  logic [16:0] f_val;
  logic [16:0] t_val;

  always_comb begin
    if (dv_fsat[DV_STAGES] || dv_fq[DV_STAGES] > ONE_Q16) f_val = ONE_Q16;
    else f_val = dv_fq[DV_STAGES];
    if (h_small) t_val = '0;
    else if (dv_tsat[DV_STAGES] || dv_tq[DV_STAGES] > ONE_Q16) t_val = ONE_Q16;
    else t_val = dv_tq[DV_STAGES];
  end

  // Scale stage: per-channel weights for the first and second color.
  logic        sc_v;
  logic [16:0] sc_wa_r;
  logic [16:0] sc_wa_g;
  logic [16:0] sc_wa_b;
  logic [16:0] sc_wb;
  logic [32:0] p_f3;
  logic [32:0] p_t3;
  logic [32:0] p_t2;
  logic [32:0] p_t1;

  assign p_f3 = f_val * K_THREE_TENTHS;
  assign p_t3 = t_val * K_THREE_TENTHS;
  assign p_t2 = t_val * K_TWO_TENTHS;
  assign p_t1 = t_val * K_ONE_TENTH;

  always_ff @(posedge clk) begin
    if (rst) sc_v <= 1'b0;
    else sc_v <= dv_v[DV_STAGES];
    case (mode)
      MODE_VIGNETTE: begin
        sc_wa_r <= ONE_Q16 - p_f3[32:16];
        sc_wa_g <= ONE_Q16 - p_f3[32:16];
        sc_wa_b <= ONE_Q16 - p_f3[32:16];
        sc_wb <= '0;
      end
      MODE_GRADIENT: begin
        sc_wa_r <= ONE_Q16 - t_val;
        sc_wa_g <= ONE_Q16 - t_val;
        sc_wa_b <= ONE_Q16 - t_val;
        sc_wb <= t_val;
      end
      MODE_SKY: begin
        sc_wa_r <= ONE_Q16 - p_t3[32:16];
        sc_wa_g <= ONE_Q16 - p_t2[32:16];
        sc_wa_b <= ONE_Q16 - p_t1[32:16];
        sc_wb <= '0;
      end
      default: begin
        sc_wa_r <= '0;
        sc_wa_g <= '0;
        sc_wa_b <= '0;
        sc_wb <= '0;
      end
    endcase
  end

  // Channel products and the output word.
  logic [23:0] col_a;
  logic [24:0] mix_r;
  logic [24:0] mix_g;
  logic [24:0] mix_b;

  assign col_a = (mode == MODE_GRADIENT) ? ramp_first_rgb : shade_rgb;
  assign mix_r = 25'(col_a[23:16] * sc_wa_r) + 25'(ramp_last_rgb[23:16] * sc_wb);
  assign mix_g = 25'(col_a[15:8] * sc_wa_g) + 25'(ramp_last_rgb[15:8] * sc_wb);
  assign mix_b = 25'(col_a[7:0] * sc_wa_b) + 25'(ramp_last_rgb[7:0] * sc_wb);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= sc_v;
    red <= mix_r[23:16];
    green <= mix_g[23:16];
    blue <= mix_b[23:16];
  end

endmodule

@@ tb/sv/tb_procedural_texture_pixel_top.sv @@
module tb_procedural_texture_pixel_top;
  import ptp_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Color prediction and in-order checking of the pixel stream.
  class pixel_scoreboard;
    logic [1:0]  mode;
    logic [12:0] width;
    logic [12:0] height;
    logic [23:0] shade_rgb;
    logic [23:0] ramp_first_rgb;
    logic [23:0] ramp_last_rgb;
    rgb_t        expected_pixels[$];
    int          errors;

    function void restore_defaults();
      mode = MODE_VIGNETTE;
      width = 13'd512;
      height = 13'd512;
      shade_rgb = 24'h87CEEB;
      ramp_first_rgb = 24'h87CEEB;
      ramp_last_rgb = 24'h4682B4;
    endfunction

    function void write_reg(logic [2:0] index, logic [23:0] data);
      case (index)
        REG_MODE: mode = data[1:0];
        REG_WIDTH: width = data[12:0];
        REG_HEIGHT: height = data[12:0];
        REG_BASE: shade_rgb = data;
        REG_TOP: ramp_first_rgb = data;
        REG_BOTTOM: ramp_last_rgb = data;
        default: ;
      endcase
    endfunction

    // Bitwise integer square root, truncated.
    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
        if (v >= root + bitpos) begin
          v = v - (root + bitpos);
          root = (root >> 1) + bitpos;
        end else begin
          root = root >> 1;
        end
        bitpos = bitpos >> 2;
      end
      return root;
    endfunction

    function longint unsigned row_fraction(longint unsigned y, longint unsigned h);
      longint unsigned t;
      if (h < 2) return 0;
      t = (y << 16) / (h - 1);
      return (t > ONE_Q16) ? ONE_Q16 : t;
    endfunction

    function logic [7:0] shade(logic [7:0] c, longint unsigned x, longint unsigned k);
      longint unsigned s;
      s = ONE_Q16 - ((x * k) >> 16);
      return 8'((c * s) >> 16);
    endfunction

    // Works out the color of one accepted pixel coordinate.
    function void note_pixel(logic [11:0] px, logic [11:0] py);
      longint unsigned w, h, d2, root_q8, den, f, t, u;
      longint signed dx, dy;
      rgb_t p;
      w = (width > MAX_SIDE) ? MAX_SIDE : width;
      h = (height > MAX_SIDE) ? MAX_SIDE : height;
      p = '0;
      case (mode)
        MODE_VIGNETTE: begin
          dx = longint'(px) - longint'(w / 2);
          dy = longint'(py) - longint'(h / 2);
          d2 = dx * dx + dy * dy;
          root_q8 = int_sqrt(d2 << 16);
          den = w * K_SEVEN_TENTHS;
          if (den == 0) begin
            f = ONE_Q16;
          end else begin
            f = (root_q8 << 24) / den;
            if (f > ONE_Q16) f = ONE_Q16;
          end
          p.red = shade(shade_rgb[23:16], f, K_THREE_TENTHS);
          p.green = shade(shade_rgb[15:8], f, K_THREE_TENTHS);
          p.blue = shade(shade_rgb[7:0], f, K_THREE_TENTHS);
        end
        MODE_GRADIENT: begin
          t = row_fraction(py, h);
          u = ONE_Q16 - t;
          p.red = 8'((ramp_first_rgb[23:16] * u + ramp_last_rgb[23:16] * t) >> 16);
          p.green = 8'((ramp_first_rgb[15:8] * u + ramp_last_rgb[15:8] * t) >> 16);
          p.blue = 8'((ramp_first_rgb[7:0] * u + ramp_last_rgb[7:0] * t) >> 16);
        end
        MODE_SKY: begin
          t = row_fraction(py, h);
          p.red = shade(shade_rgb[23:16], t, K_THREE_TENTHS);
          p.green = shade(shade_rgb[15:8], t, K_TWO_TENTHS);
          p.blue = shade(shade_rgb[7:0], t, K_ONE_TENTH);
        end
        default: ;
      endcase
      expected_pixels.push_back(p);
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel word r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.red !== want.red) begin
        $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        errors++;
      end
      if (got.green !== want.green) begin
        $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        errors++;
      end
      if (got.blue !== want.blue) begin
        $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic        done;
  logic [7:0]  red, green, blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  pixel_scoreboard colors = new();
  int          burst_left = 0;

  procedural_texture_pixel_top u_top (.*);

  always #6 clk = ~clk;

  // Results are taken at the edge that ends their cycle.
  always @(posedge clk) begin
    if (!rst && done) colors.check_pixel('{red, green, blue});
  end

  task automatic write_cfg(logic [2:0] index, logic [23:0] data);
    logic rdy;
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    do begin
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    colors.write_reg(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Sends one coordinate word; start stays high inside a burst.
  task automatic send_pixel(logic [11:0] px, logic [11:0] py);
    logic bsy;
    if (burst_left == 0) begin
      start = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    start = 1'b1;
    pos_x = px;
    pos_y = py;
    do begin
      bsy = busy;
      @(posedge clk);
    end while (bsy);
    colors.note_pixel(px, py);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    burst_left = 0;
    while (colors.expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly in-image pixels, some over the whole field range.
  task automatic random_pixels(int count);
    int unsigned w, h;
    w = (colors.width > MAX_SIDE) ? MAX_SIDE : colors.width;
    h = (colors.height > MAX_SIDE) ? MAX_SIDE : colors.height;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0 || w == 0 || h == 0)
        send_pixel(12'($urandom), 12'($urandom));
      else
        send_pixel(12'($urandom_range(0, w - 1)), 12'($urandom_range(0, h - 1)));
    end
  endtask

  initial begin
    logic [12:0] sides[6];
    colors.restore_defaults();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners and the center under the reset settings.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd256, 12'd256);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd511, 12'd511);
    drain();
    for (int m = 0; m < 4; m++) begin
      write_cfg(REG_MODE, 24'(m));
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd511, 12'd511);
      send_pixel(12'd700, 12'd600);
      send_pixel(12'd4095, 12'd4095);
      drain();
    end
    // A zero width and a one-row height, plus the unused indexes.
    write_cfg(REG_WIDTH, 24'd0);
    write_cfg(REG_HEIGHT, 24'd1);
    write_cfg(3'd6, 24'hFFFFFF);
    write_cfg(3'd7, 24'h000000);
    for (int m = 0; m < 3; m++) begin
      write_cfg(REG_MODE, 24'(m));
      send_pixel(12'd5, 12'd9);
      send_pixel(12'd4095, 12'd0);
      drain();
    end

    // Random phases, extremes of the sides included.
    sides = '{13'd2, 13'd8191, 13'd4096, 13'd3, 13'd640, 13'd1};
    for (int ph = 0; ph < 12; ph++) begin
      write_cfg(REG_MODE, 24'(ph % 4 == 3 ? $urandom_range(0, 3) : ph % 3));
      write_cfg(REG_WIDTH, ph < 6 ? 24'(sides[ph]) : 24'($urandom_range(0, 8191)));
      write_cfg(REG_HEIGHT, ph < 6 ? 24'(sides[5 - ph]) : 24'($urandom_range(0, 8191)));
      write_cfg(REG_BASE, ph == 0 ? 24'hFFFFFF : (ph == 1 ? 24'h000000 : 24'($urandom)));
      write_cfg(REG_TOP, ph == 0 ? 24'h000000 : 24'($urandom));
      write_cfg(REG_BOTTOM, ph == 0 ? 24'hFFFFFF : 24'($urandom));
      random_pixels(50);
      drain();
    end

    repeat (60) @(posedge clk);
    if (colors.errors == 0 && colors.expected_pixels.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ procedural_texture_pixel_top.f @@
hw/rtl/ptp_pkg.sv
hw/rtl/procedural_texture_pixel_top.sv
tb/sv/tb_procedural_texture_pixel_top.sv
